// ----- rtl/bnse_pkg.sv -----
// Package: shared types, constants and the symbol count table of the base-N encoder.
package bnse_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_GROUP_BYTES = 5;
    localparam int DEF_ALPHABET_DEPTH  = 64;

    // Field widths.
    localparam int BYTE_W   = 8;
    localparam int IDX_W    = 6;
    localparam int SYM_W    = 6;
    localparam int CFG3_W   = 3;
    localparam int CNT_W    = 4;
    localparam int REAL_W   = 6;
    localparam int GB_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 8;

    // Symbol widths.
    localparam logic [CFG3_W-1:0] SYM_BITS_B16 = 3'd4;
    localparam logic [CFG3_W-1:0] SYM_BITS_B32 = 3'd5;
    localparam logic [CFG3_W-1:0] SYM_BITS_B64 = 3'd6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BITS_PER_SYMBOL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_BYTES     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_CHAR        = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [CFG3_W-1:0] RST_BITS_PER_SYMBOL = 3'd6;
    localparam logic [CFG3_W-1:0] RST_GROUP_BYTES     = 3'd3;
    localparam logic [BYTE_W-1:0] RST_PAD_CHAR        = 8'd61;

    // Input item kinds carried in tuser.
    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_TABLE = 1'b1;

    // A finished group handed from the gatherer to the symbol emitter.
    typedef struct packed {
        logic              valid;
        logic [CNT_W-1:0]  count;
        logic [REAL_W-1:0] real_bits;
    } t_launch;

    // Emitter status seen by the input side.
    typedef struct packed {
        logic             busy;
        logic             free;
        logic [CNT_W-1:0] remaining;
    } t_emit_status;

    // Number of symbols for a group: ceil(8 * group / bits).
    function automatic logic [CNT_W-1:0] symbol_count(input logic [CFG3_W-1:0] group,
                                                      input logic [CFG3_W-1:0] bits);
        logic [CNT_W-1:0] cnt;
        cnt = '0;
        if (bits == SYM_BITS_B16) begin
            cnt = {group, 1'b0};
        end else if (bits == SYM_BITS_B32) begin
            unique case (group)
                3'd1:    cnt = 4'd2;
                3'd2:    cnt = 4'd4;
                3'd3:    cnt = 4'd5;
                3'd4:    cnt = 4'd7;
                3'd5:    cnt = 4'd8;
                3'd6:    cnt = 4'd10;
                3'd7:    cnt = 4'd12;
                default: cnt = 4'd0;
            endcase
        end else begin
            unique case (group)
                3'd1:    cnt = 4'd2;
                3'd2:    cnt = 4'd3;
                3'd3:    cnt = 4'd4;
                3'd4:    cnt = 4'd6;
                3'd5:    cnt = 4'd7;
                3'd6:    cnt = 4'd8;
                3'd7:    cnt = 4'd10;
                default: cnt = 4'd0;
            endcase
        end
        return cnt;
    endfunction

endpackage

// ----- rtl/bnse_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bnse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old contents when both ports hit the same entry.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/bnse_group.sv -----
// Byte gatherer: collects data bytes into a group and launches full or ended groups.
module bnse_group #(
    parameter int MAX_GROUP_BYTES = bnse_pkg::DEF_MAX_GROUP_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  logic                          i_take,
    input  logic [bnse_pkg::BYTE_W-1:0]   i_data,
    input  logic                          i_last,
    input  logic [bnse_pkg::CFG3_W-1:0]   i_group,
    input  logic [bnse_pkg::CFG3_W-1:0]   i_bits,
    output logic                          o_complete,
    output bnse_pkg::t_launch             o_launch,
    output logic [8*MAX_GROUP_BYTES-1:0]  o_aligned
);

    localparam int BUF_W = 8 * MAX_GROUP_BYTES;

    logic [BUF_W-1:0]                r_buf;
    logic [bnse_pkg::CFG3_W-1:0]     r_count;
    logic [BUF_W-1:0]                n_buf;
    logic [bnse_pkg::CFG3_W-1:0]     n_count;
    logic [BUF_W-1:0]                w_buf0;
    logic [bnse_pkg::CFG3_W-1:0]     w_n0;
    logic [bnse_pkg::GB_W-1:0]       w_n1;
    logic [BUF_W+7:0]                w_joined;
    logic [BUF_W-1:0]                w_buf1;
    logic [bnse_pkg::GB_W-1:0]       w_free_bytes;
    logic [bnse_pkg::GB_W+2:0]       w_shamt;

    // A group that already holds enough bytes restarts empty.
    always_comb begin
        if (r_count >= i_group) begin
            w_n0   = '0;
            w_buf0 = '0;
        end else begin
            w_n0   = r_count;
            w_buf0 = r_buf;
        end
    end

    // Append the new byte at the low end.
    assign w_joined = {w_buf0, i_data};
    assign w_buf1   = w_joined[BUF_W-1:0];
    assign w_n1     = {1'b0, w_n0} + bnse_pkg::GB_W'(1);

    assign o_complete = (w_n1 >= {1'b0, i_group}) || i_last;

    // Left-align the real bytes so the first byte sits at the top of the word.
    assign w_free_bytes = bnse_pkg::GB_W'(MAX_GROUP_BYTES) - w_n1;
    assign w_shamt      = {w_free_bytes, 3'b000};
    assign o_aligned    = w_buf1 << w_shamt;

    always_comb begin
        o_launch.valid     = i_take && o_complete;
        o_launch.count     = bnse_pkg::symbol_count(i_group, i_bits);
        o_launch.real_bits = {w_n1[2:0], 3'b000};
    end

    // Group state update.
    always_comb begin
        n_buf   = r_buf;
        n_count = r_count;
        if (i_clear) begin
            n_buf   = '0;
            n_count = '0;
        end else if (i_take) begin
            if (o_complete) begin
                n_buf   = '0;
                n_count = '0;
            end else begin
                n_buf   = w_buf1;
                n_count = w_n1[2:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf   <= '0;
            r_count <= '0;
        end else begin
            r_buf   <= n_buf;
            r_count <= n_count;
        end
    end

endmodule

// ----- rtl/bnse_emit.sv -----
// Symbol emitter: slices a launched group into symbols, looks them up and drives the output.
module bnse_emit #(
    parameter int MAX_GROUP_BYTES = bnse_pkg::DEF_MAX_GROUP_BYTES,
    parameter int ALPHABET_DEPTH  = bnse_pkg::DEF_ALPHABET_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bnse_pkg::t_launch                   i_launch,
    input  logic [8*MAX_GROUP_BYTES-1:0]        i_aligned,
    input  logic [bnse_pkg::CFG3_W-1:0]         i_bits,
    input  logic [bnse_pkg::BYTE_W-1:0]         i_pad_char,
    output bnse_pkg::t_emit_status              o_status,
    output logic                                o_ram_re,
    output logic [$clog2(ALPHABET_DEPTH)-1:0]   o_ram_raddr,
    input  logic [bnse_pkg::BYTE_W-1:0]         i_ram_rdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [bnse_pkg::M_TDATA_W-1:0]      o_m_tdata,
    output logic                                o_m_tlast
);

    localparam int BUF_W = 8 * MAX_GROUP_BYTES;
    localparam int SH_W  = BUF_W + bnse_pkg::SYM_W;
    localparam int AW    = $clog2(ALPHABET_DEPTH);

    logic                          r_busy;
    logic [bnse_pkg::CNT_W-1:0]    r_remaining;
    logic [bnse_pkg::REAL_W-1:0]   r_left;
    logic [SH_W-1:0]               r_shift;
    logic                          r_o_valid;
    logic                          r_o_pad;
    logic                          r_o_oob;
    logic                          r_o_last;
    logic                          n_busy;
    logic [bnse_pkg::CNT_W-1:0]    n_remaining;
    logic [bnse_pkg::REAL_W-1:0]   n_left;
    logic [SH_W-1:0]               n_shift;
    logic                          w_advance;
    logic                          w_issue;
    logic                          w_last_issue;
    logic [bnse_pkg::SYM_W-1:0]    w_top;
    logic [bnse_pkg::SYM_W-1:0]    w_sym;
    logic [bnse_pkg::REAL_W-1:0]   w_bits_ext;
    logic                          w_pad;

    // Output stage moves when it is empty or its transfer completes.
    assign w_advance    = !r_o_valid || i_m_tready;
    assign w_issue      = r_busy && w_advance;
    assign w_last_issue = w_issue && (r_remaining == bnse_pkg::CNT_W'(1));

    always_comb begin
        o_status.busy      = r_busy;
        o_status.free      = !r_busy || w_last_issue;
        o_status.remaining = r_remaining;
    end

    // Current symbol: the top bits of the shift word, right-justified.
    assign w_top      = r_shift[SH_W-1 -: bnse_pkg::SYM_W];
    assign w_sym      = w_top >> (bnse_pkg::SYM_BITS_B64 - i_bits);
    assign w_bits_ext = bnse_pkg::REAL_W'(i_bits);
    assign w_pad      = (r_left == '0);

    assign o_ram_re    = w_issue && !w_pad;
    assign o_ram_raddr = w_sym[AW-1:0];

    // Group walk: shift out one symbol per issue, a new launch reloads.
    always_comb begin
        n_busy      = r_busy;
        n_remaining = r_remaining;
        n_left      = r_left;
        n_shift     = r_shift;
        if (i_launch.valid) begin
            n_busy      = 1'b1;
            n_remaining = i_launch.count;
            n_left      = i_launch.real_bits;
            n_shift     = {i_aligned, bnse_pkg::SYM_W'(0)};
        end else if (w_issue) begin
            n_busy      = !w_last_issue;
            n_remaining = r_remaining - bnse_pkg::CNT_W'(1);
            n_left      = (r_left > w_bits_ext) ? (r_left - w_bits_ext) : '0;
            unique case (i_bits)
                bnse_pkg::SYM_BITS_B16: n_shift = r_shift << 4;
                bnse_pkg::SYM_BITS_B32: n_shift = r_shift << 5;
                default:                n_shift = r_shift << 6;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_remaining <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_remaining <= n_remaining;
            if (w_advance) begin
                r_o_valid <= w_issue;
            end
        end
    end

    // Payload side of the walk and the output stage.
    always_ff @(posedge i_clk) begin
        r_left  <= n_left;
        r_shift <= n_shift;
        if (w_issue) begin
            r_o_pad  <= w_pad;
            r_o_oob  <= ({1'b0, w_sym} >= 7'(ALPHABET_DEPTH));
            r_o_last <= w_last_issue;
        end
    end

    // Pad and out-of-range symbols bypass the alphabet.
    always_comb begin
        if (r_o_pad) begin
            o_m_tdata = i_pad_char;
        end else if (r_o_oob) begin
            o_m_tdata = '0;
        end else begin
            o_m_tdata = i_ram_rdata;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tlast  = r_o_last;

endmodule

// ----- rtl/base_n_byte_to_symbol_encoder_unit.sv -----
// Top level of the base-N byte to symbol encoder: configuration, input control and alphabet.
//
// Encodes a byte stream as base16, base32 or base64 style text. Items on the slave
// stream are either data bytes (tuser low) or alphabet writes (tuser high); a data
// byte with tlast set ends the input and flushes the open group zero-filled. Each
// group of group_bytes bytes yields ceil(8 * group_bytes / bits_per_symbol) symbols,
// one per cycle on the master stream while it is ready, the final one of a group
// marked by tlast. Symbols that start past the real input bits come out as pad_char.
// A data byte that does not close a group is taken every cycle; a closing byte or an
// alphabet write waits until the symbol emitter has issued the last symbol of the
// previous group, so the sustained rate is set by the emitter at one symbol per cycle
// while the master stream is ready, e.g. 4 symbols per 3 bytes for base64. When the
// closing byte of a group is taken, the group is loaded into the emitter; the alphabet
// RAM read and the output register then update together for its first symbol.
// Alphabet entries must be written before they are used.
module base_n_byte_to_symbol_encoder_unit #(
    parameter int MAX_GROUP_BYTES = bnse_pkg::DEF_MAX_GROUP_BYTES,
    parameter int ALPHABET_DEPTH  = bnse_pkg::DEF_ALPHABET_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input stream
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // [7:0] data_byte, [13:8] table_index, [21:14] table_value, [23:22] zero
    input  logic [bnse_pkg::S_TDATA_W-1:0]       i_s_tdata,
    // [0] opcode
    input  logic                                 i_s_tuser,
    input  logic                                 i_s_tlast,
    // Output stream
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // [7:0] out_char
    output logic [bnse_pkg::M_TDATA_W-1:0]       o_m_tdata,
    output logic                                 o_m_tlast,
    // Configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [bnse_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bnse_pkg::BYTE_W-1:0]          i_cfg_data
);

    localparam int BUF_W = 8 * MAX_GROUP_BYTES;
    localparam int AW    = $clog2(ALPHABET_DEPTH);

    logic [bnse_pkg::CFG3_W-1:0]    r_bits_per_symbol;
    logic [bnse_pkg::CFG3_W-1:0]    r_group_bytes;
    logic [bnse_pkg::BYTE_W-1:0]    r_pad_char;
    logic [bnse_pkg::CFG3_W-1:0]    w_eff_bits;
    logic [bnse_pkg::CFG3_W-1:0]    w_eff_group;
    logic                           w_cfg_wr;
    logic                           w_group_clear;
    logic                           w_s_xfer;
    logic                           w_take;
    logic                           w_table_wr;
    logic                           w_complete;
    logic                           w_blocking;
    logic [bnse_pkg::BYTE_W-1:0]    w_data_byte;
    logic [bnse_pkg::IDX_W-1:0]     w_table_index;
    logic [bnse_pkg::BYTE_W-1:0]    w_table_value;
    bnse_pkg::t_launch              w_launch;
    bnse_pkg::t_emit_status         w_status;
    logic [BUF_W-1:0]               w_aligned;
    logic                           w_ram_re;
    logic [AW-1:0]                  w_ram_raddr;
    logic [bnse_pkg::BYTE_W-1:0]    w_ram_rdata;

    assign w_data_byte   = i_s_tdata[7:0];
    assign w_table_index = i_s_tdata[13:8];
    assign w_table_value = i_s_tdata[21:14];

    // Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
    assign o_cfg_ready   = 1'b1;
    assign w_cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign w_group_clear = w_cfg_wr && (i_cfg_index == bnse_pkg::CFG_GROUP_BYTES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits_per_symbol <= bnse_pkg::RST_BITS_PER_SYMBOL;
            r_group_bytes     <= bnse_pkg::RST_GROUP_BYTES;
            r_pad_char        <= bnse_pkg::RST_PAD_CHAR;
        end else if (w_cfg_wr) begin
            unique case (i_cfg_index)
                bnse_pkg::CFG_BITS_PER_SYMBOL: r_bits_per_symbol <= i_cfg_data[2:0];
                bnse_pkg::CFG_GROUP_BYTES:     r_group_bytes     <= i_cfg_data[2:0];
                bnse_pkg::CFG_PAD_CHAR:        r_pad_char        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the settings to their usable ranges.
    always_comb begin
        if (r_bits_per_symbol < bnse_pkg::SYM_BITS_B16) begin
            w_eff_bits = bnse_pkg::SYM_BITS_B16;
        end else if (r_bits_per_symbol > bnse_pkg::SYM_BITS_B64) begin
            w_eff_bits = bnse_pkg::SYM_BITS_B64;
        end else begin
            w_eff_bits = r_bits_per_symbol;
        end
        if (r_group_bytes == '0) begin
            w_eff_group = bnse_pkg::CFG3_W'(1);
        end else if ({1'b0, r_group_bytes} > bnse_pkg::GB_W'(MAX_GROUP_BYTES)) begin
            w_eff_group = bnse_pkg::CFG3_W'(MAX_GROUP_BYTES);
        end else begin
            w_eff_group = r_group_bytes;
        end
    end

    // Alphabet writes and group-closing bytes wait for a free emitter.
    assign w_blocking = (i_s_tuser == bnse_pkg::OP_TABLE) || w_complete;
    assign o_s_tready = !w_blocking || w_status.free;
    assign w_s_xfer   = i_s_tvalid && o_s_tready;
    assign w_take     = w_s_xfer && (i_s_tuser == bnse_pkg::OP_DATA);
    assign w_table_wr = w_s_xfer && (i_s_tuser == bnse_pkg::OP_TABLE)
                        && ({1'b0, w_table_index} < 7'(ALPHABET_DEPTH));

    bnse_group #(
        .MAX_GROUP_BYTES (MAX_GROUP_BYTES)
    ) u_group (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (w_group_clear),
        .i_take     (w_take),
        .i_data     (w_data_byte),
        .i_last     (i_s_tlast),
        .i_group    (w_eff_group),
        .i_bits     (w_eff_bits),
        .o_complete (w_complete),
        .o_launch   (w_launch),
        .o_aligned  (w_aligned)
    );

    bnse_ram #(
        .WIDTH (bnse_pkg::BYTE_W),
        .DEPTH (ALPHABET_DEPTH)
    ) u_alphabet (
        .i_clk   (i_clk),
        .i_we    (w_table_wr),
        .i_waddr (w_table_index[AW-1:0]),
        .i_wdata (w_table_value),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    bnse_emit #(
        .MAX_GROUP_BYTES (MAX_GROUP_BYTES),
        .ALPHABET_DEPTH  (ALPHABET_DEPTH)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_launch    (w_launch),
        .i_aligned   (w_aligned),
        .i_bits      (w_eff_bits),
        .i_pad_char  (r_pad_char),
        .o_status    (w_status),
        .o_ram_re    (w_ram_re),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

`ifndef NO_ASSERTIONS
    // A new group is only launched into an emitter that has finished its issues.
    a_launch_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_launch.valid |-> w_status.free)
        else $error("group launched while emitter still issuing");

    // A busy emitter always has symbols left to issue.
    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.busy |-> (w_status.remaining != '0))
        else $error("emitter busy with no symbols left");

    // The alphabet never changes under a pending lookup.
    a_table_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_xfer && (i_s_tuser == bnse_pkg::OP_TABLE)) |-> w_status.free)
        else $error("alphabet written while lookups pending");
`endif

endmodule

// ----- tb/tb.sv -----
// Testbench for the base-N byte to symbol encoder: scoreboard class, stream and register drivers.
`timescale 1ns / 100ps

module tb;

    // Register index beyond the defined list; writes to it must change nothing.
    localparam logic [bnse_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int GROUP_MAX     = bnse_pkg::DEF_MAX_GROUP_BYTES;
    localparam int ALPHA_ENTRIES = bnse_pkg::DEF_ALPHABET_DEPTH;
    // Quiet cycles after the last symbol before the settings change.
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [bnse_pkg::BYTE_W-1:0] char_code;
        logic                        is_last;
    } t_enc_symbol;

    // Tracks the encoder state and holds the symbols still to come out.
    class t_symbol_tracker;
        logic [bnse_pkg::CFG3_W-1:0]   bits_reg;
        logic [bnse_pkg::CFG3_W-1:0]   group_reg;
        logic [bnse_pkg::BYTE_W-1:0]   pad_reg;
        logic [39:0]                   group_buf;
        int unsigned                   group_fill;
        logic [bnse_pkg::BYTE_W-1:0]   alphabet [ALPHA_ENTRIES];
        t_enc_symbol                   pending_symbols [$];
        int unsigned                   mismatches;

        function new();
            bits_reg   = bnse_pkg::RST_BITS_PER_SYMBOL;
            group_reg  = bnse_pkg::RST_GROUP_BYTES;
            pad_reg    = bnse_pkg::RST_PAD_CHAR;
            group_buf  = '0;
            group_fill = 0;
            mismatches = 0;
            foreach (alphabet[k]) alphabet[k] = '0;
        endfunction

        function void write_register(logic [bnse_pkg::CFG_IDX_W-1:0] idx,
                                     logic [bnse_pkg::BYTE_W-1:0] value);
            case (idx)
                bnse_pkg::CFG_BITS_PER_SYMBOL: bits_reg = value[bnse_pkg::CFG3_W-1:0];
                bnse_pkg::CFG_GROUP_BYTES: begin
                    // A new group size throws away the partial group.
                    group_reg  = value[bnse_pkg::CFG3_W-1:0];
                    group_buf  = '0;
                    group_fill = 0;
                end
                bnse_pkg::CFG_PAD_CHAR: pad_reg = value;
                default: ;
            endcase
        endfunction

        // Accepted input transfer: update the alphabet or the group, queue any symbols.
        function void note_item(logic opcode, logic [bnse_pkg::S_TDATA_W-1:0] data,
                                logic last);
            int unsigned bits, grp, gbits, count, total;
            logic [63:0] wide;
            logic [63:0] mask;
            logic [63:0] sym;
            t_enc_symbol s;
            if (opcode == bnse_pkg::OP_TABLE) begin
                alphabet[data[13:8]] = data[21:14];
                return;
            end
            // Out-of-range settings saturate to the nearest legal value.
            bits = (bits_reg < bnse_pkg::SYM_BITS_B16) ? bnse_pkg::SYM_BITS_B16 :
                   (bits_reg > bnse_pkg::SYM_BITS_B64) ? bnse_pkg::SYM_BITS_B64 : bits_reg;
            grp  = (group_reg < 1) ? 1 : (group_reg > GROUP_MAX) ? GROUP_MAX : group_reg;
            if (group_fill >= grp) begin
                group_fill = 0;
                group_buf  = '0;
            end
            group_buf  = {group_buf[31:0], data[7:0]};
            group_fill = group_fill + 1;
            if (group_fill < grp && !last) return;

            gbits = 8 * grp;
            count = (gbits + bits - 1) / bits;
            total = count * bits;
            // Left-align the real bytes, then pad with zeros to whole symbols.
            wide = 64'(group_buf) << (8 * (grp - group_fill) + total - gbits);
            mask = (64'd1 << bits) - 1;
            for (int unsigned k = 0; k < count; k++) begin
                sym = (wide >> (total - (k + 1) * bits)) & mask;
                if (k * bits >= group_fill * 8) s.char_code = pad_reg;
                else if (sym < ALPHA_ENTRIES) s.char_code = alphabet[sym[5:0]];
                else s.char_code = '0;
                s.is_last = (k + 1 == count);
                pending_symbols.push_back(s);
            end
            group_buf  = '0;
            group_fill = 0;
        endfunction

        // Accepted output transfer: compare with the oldest queued symbol.
        function void check_symbol(logic [bnse_pkg::BYTE_W-1:0] ch, logic last);
            t_enc_symbol want;
            if (pending_symbols.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected symbol char %h last %b", $time, ch, last);
                return;
            end
            want = pending_symbols.pop_front();
            if (want.char_code !== ch || want.is_last !== last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: symbol mismatch: expected char %h last %b, got char %h last %b",
                             $time, want.char_code, want.is_last, ch, last);
            end
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_s_tvalid;
    logic                            o_s_tready;
    logic [bnse_pkg::S_TDATA_W-1:0]  i_s_tdata;
    logic                            i_s_tuser;
    logic                            i_s_tlast;
    logic                            o_m_tvalid;
    logic                            i_m_tready;
    logic [bnse_pkg::M_TDATA_W-1:0]  o_m_tdata;
    logic                            o_m_tlast;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [bnse_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [bnse_pkg::BYTE_W-1:0]     i_cfg_data;

    t_symbol_tracker tracker = new();
    bit calm = 1'b0;

    base_n_byte_to_symbol_encoder_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog for a hung run.
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Output backpressure in random bursts, none once the run is calm.
    initial begin
        i_m_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (calm || $urandom_range(0, 2) != 0) begin
                i_m_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // Observe every transfer at the clock edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) tracker.write_register(i_cfg_index, i_cfg_data);
            if (i_s_tvalid && o_s_tready) tracker.note_item(i_s_tuser, i_s_tdata, i_s_tlast);
            if (o_m_tvalid && i_m_tready) tracker.check_symbol(o_m_tdata, o_m_tlast);
        end
    end

    // Present one input item, with an optional random gap first.
    task automatic send_item(input logic op, input logic [bnse_pkg::S_TDATA_W-1:0] data,
                             input logic last);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= data;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // Data byte; the unused alphabet fields carry random values.
    task automatic send_data(input logic [7:0] value, input logic last);
        send_item(bnse_pkg::OP_DATA, {2'b00, 8'($urandom), 6'($urandom), value}, last);
    endtask

    // Alphabet write; the data byte and the last flag carry random values.
    task automatic send_entry(input logic [5:0] idx, input logic [7:0] value);
        send_item(bnse_pkg::OP_TABLE, {2'b00, value, idx, 8'($urandom)}, 1'($urandom));
    endtask

    // Wait until every queued symbol has come out and the block has gone quiet.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending_symbols.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [bnse_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Apply one encoder setting, then run a stretch of random traffic.
    task automatic run_phase(input logic [2:0] bits, input logic [2:0] grp,
                             input logic [7:0] pad, input int items);
        settle();
        write_reg(bnse_pkg::CFG_BITS_PER_SYMBOL, {5'($urandom), bits});
        write_reg(bnse_pkg::CFG_GROUP_BYTES, {5'($urandom), grp});
        write_reg(bnse_pkg::CFG_PAD_CHAR, pad);
        for (int k = 0; k < items; k++) begin
            // Mostly data bytes, a few ending the input early, rare alphabet rewrites.
            if ($urandom_range(0, 9) == 0)
                send_entry(6'($urandom), 8'($urandom));
            else
                send_data(8'($urandom), $urandom_range(0, 3) == 0);
        end
    endtask

    // Main sequence.
    initial begin
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= bnse_pkg::OP_DATA;
        i_s_tlast   <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= bnse_pkg::CFG_BITS_PER_SYMBOL;
        i_cfg_data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill the whole alphabet before any symbol can read it.
        for (int k = 0; k < ALPHA_ENTRIES; k++) begin
            if (k == 0) send_entry(6'(k), 8'h00);
            else if (k == ALPHA_ENTRIES - 1) send_entry(6'(k), 8'hFF);
            else send_entry(6'(k), 8'($urandom));
        end

        // Reset setting: full groups, short groups with padding, a write inside a group.
        send_data(8'h00, 1'b0);
        send_data(8'hFF, 1'b0);
        send_data(8'hA5, 1'b0);
        send_data(8'hFF, 1'b1);
        send_data(8'h12, 1'b0);
        send_data(8'h34, 1'b1);
        send_data(8'hC3, 1'b0);
        send_entry(6'd5, 8'h41);
        send_data(8'h5A, 1'b1);

        // Settings below the legal range saturate upward.
        settle();
        write_reg(bnse_pkg::CFG_BITS_PER_SYMBOL, 8'd0);
        write_reg(bnse_pkg::CFG_GROUP_BYTES, 8'd0);
        send_data(8'hFF, 1'b0);
        send_data(8'h00, 1'b1);

        // Settings above the legal range saturate downward.
        settle();
        write_reg(bnse_pkg::CFG_BITS_PER_SYMBOL, 8'd7);
        write_reg(bnse_pkg::CFG_GROUP_BYTES, 8'd7);
        for (int k = 0; k < 5; k++) send_data(8'($urandom), 1'b0);
        send_data(8'h81, 1'b1);

        // Changing the group size drops a partial group.
        send_data(8'h77, 1'b0);
        settle();
        write_reg(bnse_pkg::CFG_GROUP_BYTES, 8'd3);
        send_data(8'h01, 1'b0);
        send_data(8'h02, 1'b0);
        send_data(8'h03, 1'b0);

        // Changing the symbol width keeps a partial group.
        send_data(8'h3C, 1'b0);
        settle();
        write_reg(bnse_pkg::CFG_BITS_PER_SYMBOL, bnse_pkg::SYM_BITS_B16);
        write_reg(CFG_SPARE, 8'($urandom));
        send_data(8'hE7, 1'b0);
        send_data(8'h18, 1'b0);

        // Random traffic across settings, the extremes among them.
        run_phase(bnse_pkg::SYM_BITS_B16, 3'd5, 8'h00, 4);
        run_phase(bnse_pkg::SYM_BITS_B32, 3'd5, 8'hFF, 5);
        run_phase(bnse_pkg::SYM_BITS_B64, 3'd1, 8'($urandom), 3);
        run_phase(bnse_pkg::SYM_BITS_B32, 3'd2, 8'($urandom), 3);
        calm = 1'b1;
        run_phase(bnse_pkg::SYM_BITS_B16, 3'd3, 8'($urandom), 7);

        settle();
        if (tracker.mismatches == 0 && tracker.pending_symbols.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
